// ===== hdl/mnrt_pkg.sv =====
// Package: opcodes, payload structs, register indexes and a shared freshness helper for the route table.
`timescale 1ns / 1ps
`default_nettype none
package mnrt_pkg;
	localparam logic [1:0] OP_HEARTBEAT = 2'd0;
	localparam logic [1:0] OP_TICK      = 2'd1;
	localparam logic [1:0] OP_INET      = 2'd2;
	localparam logic [1:0] OP_QUERY     = 2'd3;

	localparam logic [1:0] REG_SELF_ID  = 2'd0;
	localparam logic [1:0] REG_NBR_TO   = 2'd1;
	localparam logic [1:0] REG_INET_TO  = 2'd2;
	localparam logic [1:0] REG_RECOMP   = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] now_ms;
		logic [31:0] node_id;
		logic [15:0] heard_range;
		logic        online;
	} mnrt_in_t;

	typedef struct packed {
		logic [15:0] gateway_distance;
		logic        changed;
		logic [3:0]  fresh_neighbors;
		logic        path_active;
	} mnrt_out_t;

	// Wrap-safe freshness: signed (now - then) below a non-negative timeout.
	function automatic logic is_fresh(input logic [31:0] now, input logic [31:0] then,
		input logic [30:0] timeout);
		logic [31:0] d;
		begin
			d = now - then;
			is_fresh = d[31] || (d[30:0] < timeout);
		end
	endfunction
endpackage
`default_nettype wire

// ===== hdl/mesh_neighbor_route_table.sv =====
// Mesh neighbour route table. The entry memory has a single read port, so a heartbeat from
// another node walks the table once to search and once to count, and every other item walks
// it once to count; a tick then updates the route distance. The result sits in an output
// register; the next item is taken while it waits, and that item stalls before its result
// until the register is read. Reset clears valid bits and route state and loads the
// configuration defaults; the entry memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module mesh_neighbor_route_table import mnrt_pkg::*; #(
	parameter int TABLE_ENTRIES = 8,
	parameter int NO_ROUTE      = 65535
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire mnrt_in_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output mnrt_out_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [15:0] NR = 16'(NO_ROUTE);

	localparam logic [2:0] ST_IDLE = 3'd0, ST_SCAN = 3'd1, ST_WRITE = 3'd2,
		ST_COUNT = 3'd3, ST_TICK = 3'd4, ST_DONE = 3'd5;

	typedef struct packed {
		logic [31:0] node;
		logic [15:0] range;
		logic [31:0] seen;
	} entry_t;

	// configuration
	logic [31:0] self_id_q;
	logic [30:0] nbr_to_q, inet_to_q, recomp_q;
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_id_q <= '0;
			nbr_to_q  <= 31'd30000;
			inet_to_q <= 31'd60000;
			recomp_q  <= 31'd5000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SELF_ID: self_id_q <= cfg_data;
				REG_NBR_TO:  nbr_to_q  <= cfg_data[30:0];
				REG_INET_TO: inet_to_q <= cfg_data[30:0];
				REG_RECOMP:  recomp_q  <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// entry memory, one read and one write port
	entry_t mem [TABLE_ENTRIES];
	entry_t rd_q;
	logic [IW-1:0] raddr;
	logic we;
	logic [IW-1:0] waddr;
	entry_t wdata;
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	logic [TABLE_ENTRIES-1:0] used_q;
	logic [2:0] st_q;
	mnrt_in_t item_q;
	logic [CW-1:0] idx_q;       // address issued
	logic rv_q;                 // rd_q valid
	logic [IW-1:0] ridx_q;      // index of rd_q
	logic found_q, hitm_q, hits_q;
	logic [IW-1:0] match_q, stale_q, old_q;
	logic [31:0] old_seen_q;
	logic [3:0] count_q;
	logic [15:0] best_q;
	logic [15:0] dist_q;
	logic up_on_q;
	logic [31:0] up_stamp_q, rc_stamp_q;
	logic [15:0] prev_q;
	mnrt_out_t res_q;
	logic ov_q;

	assign raddr = idx_q[IW-1:0];
	assign in_ready = (st_q == ST_IDLE);
	assign out_valid = ov_q;
	assign out_data = res_q;

	logic r_used, r_fresh;
	logic [31:0] dseen;
	logic [IW-1:0] tgt;
	logic [15:0] r1;
	logic pa;
	always_comb begin
		r_used  = used_q[ridx_q];
		r_fresh = r_used && is_fresh(item_q.now_ms, rd_q.seen, nbr_to_q);
		dseen   = rd_q.seen - old_seen_q;
		r1      = rd_q.range + 16'd1;
		tgt     = hitm_q ? match_q : (hits_q ? stale_q : old_q);
		pa      = up_on_q && is_fresh(item_q.now_ms, up_stamp_q, inet_to_q);
		we      = (st_q == ST_WRITE);
		waddr   = tgt;
		wdata.node  = item_q.node_id;
		wdata.range = item_q.heard_range;
		wdata.seen  = item_q.now_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; ov_q <= 1'b0; used_q <= '0; idx_q <= '0; rv_q <= 1'b0;
			dist_q <= NR; up_on_q <= 1'b0; up_stamp_q <= '0; rc_stamp_q <= '0;
		end else begin
			if (ov_q && out_ready && st_q != ST_DONE) ov_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (in_valid && in_ready) begin
					item_q <= in_data; idx_q <= CW'(1); rv_q <= 1'b1; ridx_q <= '0;
					hitm_q <= 1'b0; hits_q <= 1'b0; found_q <= 1'b0; old_q <= '0;
					count_q <= '0; best_q <= NR; prev_q <= dist_q;
					if (in_data.op == OP_HEARTBEAT && in_data.node_id != self_id_q)
						st_q <= ST_SCAN;
					else begin
						st_q <= ST_COUNT;
						if (in_data.op == OP_INET) begin
							up_on_q <= in_data.online; up_stamp_q <= in_data.now_ms;
							dist_q <= in_data.online ? 16'd0 : NR;
							if (!in_data.online) rc_stamp_q <= '0;
						end
					end
				end
				// search for match, first stale slot, oldest slot
				ST_SCAN: begin
					if (ridx_q == '0) old_seen_q <= rd_q.seen;
					if (r_used && rd_q.node == item_q.node_id && !hitm_q) begin
						hitm_q <= 1'b1; match_q <= ridx_q;
					end
					if (!found_q) begin
						if (!r_fresh) begin
							found_q <= 1'b1; hits_q <= 1'b1; stale_q <= ridx_q;
						end else if (ridx_q != '0 && dseen[31]) begin
							old_q <= ridx_q; old_seen_q <= rd_q.seen;
						end
					end
					if (32'(ridx_q) == TABLE_ENTRIES - 1) st_q <= ST_WRITE;
					else begin
						ridx_q <= ridx_q + 1'b1;
						idx_q <= (32'(idx_q) == TABLE_ENTRIES - 1) ? '0 : idx_q + 1'b1;
					end
				end
				ST_WRITE: begin
					used_q[tgt] <= 1'b1; st_q <= ST_COUNT; idx_q <= '0; rv_q <= 1'b0;
					ridx_q <= '0;
				end
				// count fresh entries, best range; read issued next cycle after write
				ST_COUNT: begin
					if (!rv_q) begin
						rv_q <= 1'b1; idx_q <= CW'(1);
					end else begin
						if (r_fresh) begin
							if (count_q != 4'd15) count_q <= count_q + 4'd1;
							if (rd_q.range < NR - 16'd1 && r1 < best_q) best_q <= r1;
						end
						if (32'(ridx_q) == TABLE_ENTRIES - 1)
							st_q <= (item_q.op == OP_TICK) ? ST_TICK : ST_DONE;
						else begin
							ridx_q <= ridx_q + 1'b1;
							idx_q <= (32'(idx_q) == TABLE_ENTRIES - 1) ? '0 : idx_q + 1'b1;
						end
					end
				end
				ST_TICK: begin
					if (up_on_q && !pa) begin
						up_on_q <= 1'b0; dist_q <= best_q; rc_stamp_q <= item_q.now_ms;
					end else if (pa) dist_q <= 16'd0;
					else if (rc_stamp_q == '0 ||
						!is_fresh(item_q.now_ms, rc_stamp_q, recomp_q)) begin
						dist_q <= best_q; rc_stamp_q <= item_q.now_ms;
					end
					st_q <= ST_DONE;
				end
				// load the output register once it is free or being read
				ST_DONE: if (!ov_q || out_ready) begin
					res_q.gateway_distance <= pa ? 16'd0 : dist_q;
					res_q.changed <= (item_q.op == OP_TICK) && (prev_q != dist_q);
					res_q.fresh_neighbors <= count_q;
					res_q.path_active <= pa;
					ov_q <= 1'b1; st_q <= ST_IDLE; idx_q <= '0; rv_q <= 1'b0;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("item taken twice");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data))) else $error("result lost");
	a_active_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.path_active) |-> out_data.gateway_distance == 16'd0)
		else $error("active path with distance");
`endif
endmodule
`default_nettype wire
